[design/xdld_pkg.sv]
// ----------------------------------------------------------------------------
// xdld_pkg
// Shared types and constants for the xor decrypt loop detector.
// ----------------------------------------------------------------------------
package xdld_pkg;

  localparam int POS_WIDTH      = 24;
  localparam int TARGET_ENTRIES = 16;
  localparam int QUEUE_DEPTH    = 2;

  // Dalvik opcodes of interest
  localparam logic [7:0] OP_ARRAY_LENGTH  = 8'h21;
  localparam logic [7:0] OP_GOTO          = 8'h28;
  localparam logic [7:0] OP_IF_LT         = 8'h34;
  localparam logic [7:0] OP_IF_GE         = 8'h35;
  localparam logic [7:0] OP_XOR_INT       = 8'h97;
  localparam logic [7:0] OP_XOR_INT_2ADDR = 8'hb7;

  typedef struct packed {
    logic [7:0]           opcode;
    logic [POS_WIDTH-1:0] position;
    logic signed [7:0]    branch_offset;
    logic                 last_in_method;
  } item_t;

  typedef struct packed {
    logic abnormal;
    logic table_overflow;
  } result_t;

  // Classified instruction handed from front to back
  typedef struct packed {
    logic                 ins_a_vld;  // array-length position, inserted first
    logic [POS_WIDTH-1:0] ins_a_pos;
    logic                 ins_b_vld;  // if-ge position, inserted second
    logic [POS_WIDTH-1:0] ins_b_pos;
    logic                 is_xor;
    logic                 is_goto;
    logic [POS_WIDTH-1:0] goto_tgt;
    logic                 last;
  } cmd_t;

endpackage

[design/xdld_fifo.sv]
// ----------------------------------------------------------------------------
// xdld_fifo
// Small synchronous queue with registered storage and push/pop handshake.
// ----------------------------------------------------------------------------
module xdld_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = xdld_pkg::QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     wdata_i,
  output logic full_o,
  input  logic pop_i,
  output T     rdata_o,
  output logic empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  T              mem_q [DEPTH];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

[design/xdld_front.sv]
// ----------------------------------------------------------------------------
// xdld_front
// Decodes each instruction into a command: pending inserts, xor mark,
// goto target. Tracks the array-length lookbehind.
// ----------------------------------------------------------------------------
module xdld_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  xdld_pkg::item_t item_i,
  output xdld_pkg::cmd_t  cmd_o
);

  localparam int PW = xdld_pkg::POS_WIDTH;

  logic          prev_al_q, prev_al_d;
  logic [PW-1:0] prev_pos_q, prev_pos_d;
  logic          is_al, is_if;

  assign is_al = (item_i.opcode == xdld_pkg::OP_ARRAY_LENGTH);
  assign is_if = (item_i.opcode == xdld_pkg::OP_IF_LT) ||
                 (item_i.opcode == xdld_pkg::OP_IF_GE);

  always_comb begin
    cmd_o.ins_a_vld = prev_al_q && is_if;
    cmd_o.ins_a_pos = prev_pos_q;
    cmd_o.ins_b_vld = (item_i.opcode == xdld_pkg::OP_IF_GE);
    cmd_o.ins_b_pos = item_i.position;
    cmd_o.is_xor    = (item_i.opcode == xdld_pkg::OP_XOR_INT) ||
                      (item_i.opcode == xdld_pkg::OP_XOR_INT_2ADDR);
    cmd_o.is_goto   = (item_i.opcode == xdld_pkg::OP_GOTO);
    // offset is in 16-bit code units: sign-extend and double, wrap
    cmd_o.goto_tgt  = item_i.position +
                      {{(PW-9){item_i.branch_offset[7]}}, item_i.branch_offset, 1'b0};
    cmd_o.last      = item_i.last_in_method;
  end

  // lookbehind survives only to the next instruction of the same method
  always_comb begin
    prev_al_d  = prev_al_q;
    prev_pos_d = prev_pos_q;
    if (accept_i) begin
      prev_al_d = is_al && !item_i.last_in_method;
      if (is_al) begin
        prev_pos_d = item_i.position;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_al_q  <= 1'b0;
      prev_pos_q <= '0;
    end else begin
      prev_al_q  <= prev_al_d;
      prev_pos_q <= prev_pos_d;
    end
  end

endmodule

[design/xdld_back.sv]
// ----------------------------------------------------------------------------
// xdld_back
// Executes commands against the parallel-compare target store and keeps
// the per-method flags. Emits the verdict on the method's last command.
// ----------------------------------------------------------------------------
module xdld_back #(
  parameter int TARGET_ENTRIES = xdld_pkg::TARGET_ENTRIES
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  xdld_pkg::cmd_t   cmd_i,
  output logic             cmd_pop_o,
  input  logic             res_full_i,
  output logic             res_push_o,
  output xdld_pkg::result_t res_o
);

  localparam int PW = xdld_pkg::POS_WIDTH;
  localparam int TE = TARGET_ENTRIES;

  logic [PW-1:0] pos_q [TE];
  logic [TE-1:0] valid_q, valid_d;
  logic          xor_q, xor_d;
  logic          found_q, found_d;
  logic          ovf_q, ovf_d;

  logic          go, active;
  logic [TE-1:0] match_a, match_b, match_g;
  logic [TE-1:0] free_a, free_b, sel_a, sel_b, valid_a;
  logic          hit_a, hit_b, hit_g, do_a, do_b, ovf_a, ovf_b;

  assign go         = cmd_valid_i && (!cmd_i.last || !res_full_i);
  assign cmd_pop_o  = go;
  assign res_push_o = go && cmd_i.last;
  assign active     = !found_q;

  always_comb begin
    for (int i = 0; i < TE; i++) begin
      match_a[i] = valid_q[i] && (pos_q[i] == cmd_i.ins_a_pos);
      match_b[i] = valid_q[i] && (pos_q[i] == cmd_i.ins_b_pos);
      match_g[i] = valid_q[i] && (pos_q[i] == cmd_i.goto_tgt);
    end

    // first insert: lowest free slot
    hit_a   = |match_a;
    do_a    = active && cmd_i.ins_a_vld && !hit_a;
    free_a  = ~valid_q;
    sel_a   = do_a ? (free_a & (~free_a + TE'(1))) : '0;
    ovf_a   = do_a && (free_a == '0);
    valid_a = valid_q | sel_a;

    // second insert sees the first one's slot
    hit_b  = (|match_b) || ((|sel_a) && (cmd_i.ins_a_pos == cmd_i.ins_b_pos));
    do_b   = active && cmd_i.ins_b_vld && !hit_b;
    free_b = ~valid_a;
    sel_b  = do_b ? (free_b & (~free_b + TE'(1))) : '0;
    ovf_b  = do_b && (free_b == '0);

    hit_g   = |match_g;
    xor_d   = xor_q || (active && cmd_i.is_xor);
    found_d = found_q || (active && cmd_i.is_goto && xor_q && hit_g);
    ovf_d   = ovf_q || ovf_a || ovf_b;
    valid_d = valid_a | sel_b;

    res_o.abnormal       = found_d;
    res_o.table_overflow = ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      xor_q   <= 1'b0;
      found_q <= 1'b0;
      ovf_q   <= 1'b0;
    end else if (go) begin
      if (cmd_i.last) begin
        valid_q <= '0;
        xor_q   <= 1'b0;
        found_q <= 1'b0;
        ovf_q   <= 1'b0;
      end else begin
        valid_q <= valid_d;
        xor_q   <= xor_d;
        found_q <= found_d;
        ovf_q   <= ovf_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TE; i++) begin
      if (go && sel_a[i]) begin
        pos_q[i] <= cmd_i.ins_a_pos;
      end else if (go && sel_b[i]) begin
        pos_q[i] <= cmd_i.ins_b_pos;
      end
    end
  end

endmodule

[design/xor_decrypt_loop_detector_core.sv]
// ----------------------------------------------------------------------------
// xor_decrypt_loop_detector_core
// Flags methods whose Dalvik instruction stream shows an xor decrypt loop.
// ----------------------------------------------------------------------------
// Throughput: one instruction per cycle, set by the parallel compare of the
//   target store in the back end, unless a full result queue stalls it.
// Verdict path: the last command is registered in the command queue and its
//   verdict in the result queue before it shows on result_o.
// Reset: clears store valid bits, method flags and both queues; the block
//   accepts instructions as soon as reset is released.
module xor_decrypt_loop_detector_core #(
  parameter int TARGET_ENTRIES = xdld_pkg::TARGET_ENTRIES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  xdld_pkg::item_t   item_i,
  output logic              empty,
  input  logic              pop,
  output xdld_pkg::result_t result_o
);

  xdld_pkg::cmd_t    fe_cmd, be_cmd;
  xdld_pkg::result_t be_res;
  logic              accept, cmd_empty, cmd_pop, res_full, res_push;

  assign accept = push && !full;

  xdld_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item_i),
    .cmd_o    (fe_cmd)
  );

  xdld_fifo #(
    .T     (xdld_pkg::cmd_t),
    .DEPTH (xdld_pkg::QUEUE_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (fe_cmd),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .rdata_o (be_cmd),
    .empty_o (cmd_empty)
  );

  xdld_back #(
    .TARGET_ENTRIES (TARGET_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (be_cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (be_res)
  );

  xdld_fifo #(
    .T     (xdld_pkg::result_t),
    .DEPTH (xdld_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (be_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (result_o),
    .empty_o (empty)
  );

endmodule

[design/xdld_checker.sv]
// ----------------------------------------------------------------------------
// xdld_checker
// Port-level checks for the xor decrypt loop detector, bound to the top.
// ----------------------------------------------------------------------------
module xdld_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              push,
  input logic              full,
  input xdld_pkg::item_t   item_i,
  input logic              empty,
  input logic              pop,
  input xdld_pkg::result_t result_o
);

  // out of reset both sides are idle and ready
  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> empty && !full)
    else $error("not idle after reset");

  // the instruction side only backs up behind pending results
  a_full_needs_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty |-> !full)
    else $error("input full with no result pending");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("pending result dropped");

  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(result_o))
    else $error("pending result changed");

endmodule

bind xor_decrypt_loop_detector_core xdld_checker u_xdld_checker (.*);

[tb/xor_decrypt_loop_detector_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_decrypt_loop_detector_core_test
// Feeds method instruction streams to the xor loop detector: a short table
// of hand-picked methods, then random loop-shaped, crowded and noise methods.
// Table verdicts are checked as listed, random ones against an in-bench scan.
// ----------------------------------------------------------------------------
module xor_decrypt_loop_detector_core_test;
  import xdld_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned MAX_REPORTS  = 10;

  // opcodes the detector does not act on
  localparam logic [7:0] OP_NOP  = 8'h00;
  localparam logic [7:0] OP_FILL = 8'hff;

  localparam result_t R_CLEAN = 2'b00;
  localparam result_t R_LOOP  = 2'b10;
  localparam result_t R_OVF   = 2'b01;

  typedef struct {
    item_t   instr;
    int      reps;
    int      stride;
    bit      typed;
    result_t want;
  } dir_row_t;

  logic    clk_i  = 1'b0;
  logic    rst_ni = 1'b0;
  logic    push   = 1'b0;
  logic    full;
  item_t   item_i = '0;
  logic    empty;
  logic    pop    = 1'b0;
  result_t result_o;

  // scan state
  logic [POS_WIDTH-1:0] head_pos [TARGET_ENTRIES];
  bit                   head_vld [TARGET_ENTRIES];
  bit                   saw_xor;
  bit                   loop_found;
  bit                   pend_alen;
  bit                   heads_dropped;
  logic [POS_WIDTH-1:0] alen_pos;

  result_t     verdict_q [$];
  dir_row_t    dir_rows [$];
  item_t       method_q [$];
  int unsigned err_cnt   = 0;
  int unsigned cycle_cnt = 0;
  bit          steady    = 1'b0;

  xor_decrypt_loop_detector_core DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .item_i   (item_i),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("xor_decrypt_loop_detector_core_test: FAIL");
      $finish;
    end
  end

  function automatic void clear_scan();
    foreach (head_vld[i]) begin
      head_vld[i] = 1'b0;
      head_pos[i] = '0;
    end
    saw_xor       = 1'b0;
    loop_found    = 1'b0;
    pend_alen     = 1'b0;
    heads_dropped = 1'b0;
    alen_pos      = '0;
  endfunction

  function automatic bit head_known(logic [POS_WIDTH-1:0] p);
    foreach (head_vld[i])
      if (head_vld[i] && head_pos[i] == p) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void record_head(logic [POS_WIDTH-1:0] p);
    if (head_known(p)) return;
    foreach (head_vld[i])
      if (!head_vld[i]) begin
        head_vld[i] = 1'b1;
        head_pos[i] = p;
        return;
      end
    heads_dropped = 1'b1;
  endfunction

  // Advances the scan by one instruction; returns 1 when a verdict is due.
  function automatic bit scan_instr(input item_t it, output result_t verdict);
    logic [POS_WIDTH-1:0] dest;
    if (!loop_found) begin
      if (pend_alen && (it.opcode == OP_IF_LT || it.opcode == OP_IF_GE))
        record_head(alen_pos);
      pend_alen = 1'b0;
      case (it.opcode)
        OP_ARRAY_LENGTH: begin
          pend_alen = 1'b1;
          alen_pos  = it.position;
        end
        OP_IF_GE: record_head(it.position);
        OP_XOR_INT, OP_XOR_INT_2ADDR: saw_xor = 1'b1;
        OP_GOTO: begin
          // offset is in code units: sign-extend and double, wrap at POS_WIDTH
          dest = it.position +
                 {{(POS_WIDTH-9){it.branch_offset[7]}}, it.branch_offset, 1'b0};
          if (saw_xor && head_known(dest)) loop_found = 1'b1;
        end
        default: ;
      endcase
    end
    verdict.abnormal       = loop_found;
    verdict.table_overflow = heads_dropped;
    if (!it.last_in_method) return 1'b0;
    clear_scan();
    return 1'b1;
  endfunction

  function automatic item_t make_instr(logic [7:0] op, logic [POS_WIDTH-1:0] pos,
                                       logic signed [7:0] off, logic last);
    item_t it;
    it.opcode         = op;
    it.position       = pos;
    it.branch_offset  = off;
    it.last_in_method = last;
    return it;
  endfunction

  function automatic void add_row(item_t instr, int reps, int stride, bit typed,
                                  result_t want);
    dir_row_t r;
    r.instr  = instr;
    r.reps   = reps;
    r.stride = stride;
    r.typed  = typed;
    r.want   = want;
    dir_rows.push_back(r);
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Random method: noise, crowded (fills the head store) or loop-shaped.
  function automatic void build_method();
    logic [POS_WIDTH-1:0]        pc;
    logic [POS_WIDTH-1:0]        heads [$];
    logic signed [POS_WIDTH-1:0] reach;
    logic [7:0]                  op;
    logic signed [7:0]           off;
    int unsigned                 len, kind, pick;
    bit                          follow;
    method_q.delete();
    kind   = $urandom_range(0, 99);
    follow = 1'b0;
    pc     = POS_WIDTH'($urandom);
    if ($urandom_range(0, 3) == 0)
      pc = {POS_WIDTH{1'b1}} - POS_WIDTH'($urandom_range(0, 60));
    if (kind < 20)      len = $urandom_range(1, 20);
    else if (kind < 35) len = $urandom_range(16, 30);
    else                len = $urandom_range(3, 30);
    for (int n = 0; n < len; n++) begin
      off = 8'($urandom);
      if (kind < 20) begin
        op = 8'($urandom);
        method_q.push_back(make_instr(op, POS_WIDTH'($urandom), off, 1'b0));
      end else begin
        pick = $urandom_range(0, 99);
        if (follow && pick < 75) begin
          op = ($urandom_range(0, 1) != 0) ? OP_IF_LT : OP_IF_GE;
        end else if (kind < 35) begin
          if (pick < 55)      op = OP_IF_GE;
          else if (pick < 70) op = OP_ARRAY_LENGTH;
          else if (pick < 80) op = ($urandom_range(0, 1) != 0) ? OP_XOR_INT : OP_XOR_INT_2ADDR;
          else if (pick < 90) op = OP_GOTO;
          else                op = 8'($urandom);
        end else begin
          if (pick < 25)      op = 8'($urandom);
          else if (pick < 45) op = OP_ARRAY_LENGTH;
          else if (pick < 60) op = OP_IF_GE;
          else if (pick < 72) op = ($urandom_range(0, 1) != 0) ? OP_XOR_INT : OP_XOR_INT_2ADDR;
          else                op = OP_GOTO;
        end
        follow = (op == OP_ARRAY_LENGTH);
        if (op == OP_GOTO && heads.size() != 0 && $urandom_range(0, 3) != 0) begin
          reach = heads[$urandom_range(0, heads.size() - 1)] - pc;
          if (reach >= -256 && reach <= 254) off = reach[8:1];
        end
        // crowded methods revisit heads now and then
        if (op == OP_IF_GE && kind < 35 && heads.size() != 0 && $urandom_range(0, 4) == 0)
          method_q.push_back(make_instr(op, heads[$urandom_range(0, heads.size() - 1)],
                                        off, 1'b0));
        else
          method_q.push_back(make_instr(op, pc, off, 1'b0));
        if (op == OP_IF_GE || op == OP_ARRAY_LENGTH) heads.push_back(pc);
        pc = pc + POS_WIDTH'(2 * $urandom_range(1, 3));
      end
    end
    method_q[method_q.size() - 1].last_in_method = 1'b1;
  endfunction

  task automatic send_instr(input item_t it, input bit typed, input result_t want);
    int unsigned gap;
    result_t     verdict;
    gap = idle_len();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push   <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (scan_instr(it, verdict)) verdict_q.push_back(typed ? want : verdict);
  endtask

  initial begin : result_side
    int unsigned hold;
    result_t     want;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (verdict_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: unexpected verdict abnormal=%0d table_overflow=%0d",
                     $time, result_o.abnormal, result_o.table_overflow);
        end else begin
          want = verdict_q.pop_front();
          if (result_o.abnormal !== want.abnormal ||
              result_o.table_overflow !== want.table_overflow) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
              $display("%0t: mismatch abnormal exp %0d got %0d, overflow exp %0d got %0d",
                       $time, want.abnormal, result_o.abnormal,
                       want.table_overflow, result_o.table_overflow);
          end
        end
      end
      if (hold != 0) begin
        hold--;
        pop <= 1'b0;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
        hold = idle_len();
        pop  <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : instr_side
    item_t       it;
    result_t     none;
    int unsigned sent;
    none = R_CLEAN;
    clear_scan();

    // lone last instruction straight after reset
    add_row(make_instr(OP_NOP, 0, 0, 1), 1, 0, 1, R_CLEAN);
    // xor, if-ge head, backward goto; the rest of the method is ignored
    add_row(make_instr(OP_XOR_INT, 'h10, 0, 0), 1, 0, 0, none);
    add_row(make_instr(OP_IF_GE, 'h20, 0, 0), 1, 0, 0, none);
    add_row(make_instr(OP_GOTO, 'h30, -8, 0), 1, 0, 0, none);
    add_row(make_instr(OP_IF_GE, 'h40, 0, 0), 1, 0, 0, none);
    add_row(make_instr(OP_FILL, 24'hffffff, 127, 1), 1, 0, 1, R_LOOP);
    // array-length + if-lt head near the top, goto wraps below zero
    add_row(make_instr(OP_ARRAY_LENGTH, 24'hfffff0, 0, 0), 1, 0, 0, none);
    add_row(make_instr(OP_IF_LT, 24'hfffff4, 0, 0), 1, 0, 0, none);
    add_row(make_instr(OP_XOR_INT_2ADDR, 'h2, 0, 0), 1, 0, 0, none);
    add_row(make_instr(OP_GOTO, 'h10, -16, 1), 1, 0, 1, R_LOOP);
    // goto with no xor before it
    add_row(make_instr(OP_IF_GE, 'h100, 0, 0), 1, 0, 0, none);
    add_row(make_instr(OP_GOTO, 'h104, -2, 0), 1, 0, 0, none);
    add_row(make_instr(OP_XOR_INT, 'h108, 0, 1), 1, 0, 1, R_CLEAN);
    // most negative offset
    add_row(make_instr(OP_IF_GE, 'h0, 0, 0), 1, 0, 0, none);
    add_row(make_instr(OP_XOR_INT, 'h80, 0, 0), 1, 0, 0, none);
    add_row(make_instr(OP_GOTO, 'h100, -128, 1), 1, 0, 1, R_LOOP);
    // most positive offset, array-length as the final instruction
    add_row(make_instr(OP_XOR_INT, 'h0, 0, 0), 1, 0, 0, none);
    add_row(make_instr(OP_GOTO, 'h0, 127, 0), 1, 0, 0, none);
    add_row(make_instr(OP_ARRAY_LENGTH, 'h20, 0, 1), 1, 0, 1, R_CLEAN);
    // nothing may survive the previous verdicts
    add_row(make_instr(OP_XOR_INT, 'h0, 0, 0), 1, 0, 0, none);
    add_row(make_instr(OP_GOTO, 'h24, -2, 1), 1, 0, 1, R_CLEAN);
    // fill the store, repeat a head, then one more new head gets dropped
    add_row(make_instr(OP_IF_GE, 'h400, 0, 0), TARGET_ENTRIES, 2, 0, none);
    add_row(make_instr(OP_IF_GE, 'h400, 0, 0), 1, 0, 0, none);
    add_row(make_instr(OP_IF_GE, 'h800, 0, 1), 1, 0, 1, R_OVF);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[r])
      for (int k = 0; k < dir_rows[r].reps; k++) begin
        it = dir_rows[r].instr;
        it.position = it.position + POS_WIDTH'(k * dir_rows[r].stride);
        if (k != dir_rows[r].reps - 1) it.last_in_method = 1'b0;
        send_instr(it, dir_rows[r].typed && k == dir_rows[r].reps - 1, dir_rows[r].want);
      end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) steady = ~steady;
      build_method();
      foreach (method_q[i]) send_instr(method_q[i], 1'b0, none);
      sent += method_q.size();
    end
    push <= 1'b0;
    steady = 1'b0;

    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && verdict_q.size() == 0)
      $display("xor_decrypt_loop_detector_core_test: PASS");
    else
      $display("xor_decrypt_loop_detector_core_test: FAIL");
    $finish;
  end

endmodule
